FILE: rtl/taq_pkg.sv
// Shared types and constants for the threshold alarm qualifier.
`default_nettype none
package taq_pkg;

  localparam int unsigned LEVEL_W = 24;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Register map of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARN_LEVEL    = 2'd0,
    CFG_CRIT_LEVEL    = 2'd1,
    CFG_HYST_FRACTION = 2'd2,
    CFG_MIN_HOLD_MS   = 2'd3
  } cfg_idx_t;

  localparam logic signed [LEVEL_W-1:0] WARN_LEVEL_RST    = 24'sd512;
  localparam logic signed [LEVEL_W-1:0] CRIT_LEVEL_RST    = 24'sd1024;
  localparam logic [FRAC_W-1:0]         HYST_FRACTION_RST = 16'd6554;
  localparam logic [HOLD_W-1:0]         MIN_HOLD_MS_RST   = 16'd100;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic signed [LEVEL_W-1:0] warn_level;
    logic signed [LEVEL_W-1:0] crit_level;
    logic [FRAC_W-1:0]         hyst_fraction;
    logic [HOLD_W-1:0]         min_hold_ms;
  } taq_cfg_t;

  typedef struct packed {
    logic                active;
    logic                pending;
    logic [TIME_W-1:0]   start_time;
    logic [COUNT_W-1:0]  run_count;
  } taq_state_t;

  typedef struct packed {
    logic                      severity;
    logic signed [LEVEL_W-1:0] event_value;
    logic signed [LEVEL_W-1:0] crossed_level;
    logic [TIME_W-1:0]         held_ms;
    logic [TIME_W-1:0]         event_time;
    logic [COUNT_W-1:0]        event_count;
  } taq_result_t;

endpackage
`default_nettype wire

FILE: rtl/taq_in_if.sv
// Sample channel: valid/ready with sample and timestamp payload.
`default_nettype none
interface taq_in_if;
  import taq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] sample;
  logic [TIME_W-1:0]         now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface
`default_nettype wire

FILE: rtl/taq_out_if.sv
// Event channel: valid/ready with the alarm event payload.
`default_nettype none
interface taq_out_if;
  import taq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      severity;
  logic signed [LEVEL_W-1:0] event_value;
  logic signed [LEVEL_W-1:0] crossed_level;
  logic [TIME_W-1:0]         held_ms;
  logic [TIME_W-1:0]         event_time;
  logic [COUNT_W-1:0]        event_count;

  modport source (output valid, output severity, output event_value, output crossed_level,
                  output held_ms, output event_time, output event_count, input ready);
  modport sink   (input valid, input severity, input event_value, input crossed_level,
                  input held_ms, input event_time, input event_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/taq_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
`default_nettype none
interface taq_cfg_if;
  import taq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/taq_cfg.sv
// Configuration register file of the threshold alarm qualifier.
`default_nettype none
module taq_cfg (
  input  wire              clk,
  input  wire              rst_n,
  taq_cfg_if.sink          cfg_bus,
  output taq_pkg::taq_cfg_t cfg
);
  import taq_pkg::*;

  taq_cfg_t cfg_r;

  // always able to take a write
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn_level    <= WARN_LEVEL_RST;
      cfg_r.crit_level    <= CRIT_LEVEL_RST;
      cfg_r.hyst_fraction <= HYST_FRACTION_RST;
      cfg_r.min_hold_ms   <= MIN_HOLD_MS_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_idx_t'(cfg_bus.index))
        CFG_WARN_LEVEL:    cfg_r.warn_level    <= $signed(cfg_bus.data[LEVEL_W-1:0]);
        CFG_CRIT_LEVEL:    cfg_r.crit_level    <= $signed(cfg_bus.data[LEVEL_W-1:0]);
        CFG_HYST_FRACTION: cfg_r.hyst_fraction <= cfg_bus.data[FRAC_W-1:0];
        CFG_MIN_HOLD_MS:   cfg_r.min_hold_ms   <= cfg_bus.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: rtl/taq_eval.sv
// Single-pass evaluation of one sample: thresholds, hold timer, next state.
`default_nettype none
module taq_eval (
  input  taq_pkg::taq_cfg_t         cfg,
  input  taq_pkg::taq_state_t       st,
  input  wire signed [23:0]         sample,
  input  wire [31:0]                now_ms,
  output taq_pkg::taq_state_t       st_nxt,
  output logic                      res_valid,
  output taq_pkg::taq_result_t      res
);
  import taq_pkg::*;

  localparam int unsigned PROD_W = LEVEL_W + FRAC_W + 2;

  logic                     crit;
  logic                     warn;
  logic                     below;
  logic [FRAC_W:0]          hyst_comp;
  logic signed [PROD_W-1:0] clr_rhs;
  logic signed [PROD_W-1:0] clr_lhs;
  logic                     clear;
  logic [TIME_W-1:0]        start_eff;
  logic [TIME_W-1:0]        held;
  logic                     qualify;
  logic [COUNT_W-1:0]       count_inc;

  assign crit  = sample >= cfg.crit_level;
  assign warn  = !crit && (sample >= cfg.warn_level);
  assign below = !crit && !warn;

  // clear point: sample * 2^16 < warn * (2^16 - hyst), exact
  assign hyst_comp = {1'b1, {FRAC_W{1'b0}}} - {1'b0, cfg.hyst_fraction};
  assign clr_rhs   = cfg.warn_level * $signed({1'b0, hyst_comp});
  assign clr_lhs   = $signed({{(PROD_W-LEVEL_W-FRAC_W){sample[LEVEL_W-1]}}, sample,
                              {FRAC_W{1'b0}}});
  assign clear     = !st.active || (clr_lhs < clr_rhs);

  // timer starts on first excursion sample after a clear
  assign start_eff = st.pending ? st.start_time : now_ms;
  assign held      = now_ms - start_eff;
  assign qualify   = !below && (held >= {{(TIME_W-HOLD_W){1'b0}}, cfg.min_hold_ms})
                     && !(warn && st.active);
  assign count_inc = (st.run_count != COUNT_MAX) ? st.run_count + 1'b1 : st.run_count;

  always_comb begin
    st_nxt = st;
    if (below) begin
      if (clear) begin
        st_nxt.active    = 1'b0;
        st_nxt.pending   = 1'b0;
        st_nxt.run_count = '0;
      end
    end else begin
      st_nxt.pending    = 1'b1;
      st_nxt.start_time = start_eff;
      if (qualify) begin
        st_nxt.active    = 1'b1;
        st_nxt.run_count = count_inc;
      end
    end
  end

  assign res_valid         = qualify;
  assign res.severity      = crit;
  assign res.event_value   = sample;
  assign res.crossed_level = crit ? cfg.crit_level : cfg.warn_level;
  assign res.held_ms       = held;
  assign res.event_time    = now_ms;
  assign res.event_count   = count_inc;

endmodule
`default_nettype wire

FILE: rtl/threshold_alarm_qualifier_top.sv
// Top level of the two-level threshold alarm qualifier with hysteresis.
// Stages: a sample beat is registered in stage 1 and evaluated there; its event
//   beat, if any, is registered in the result stage and offered from it (two register stages).
// Throughput: one sample beat per cycle unless the event receiver stalls an event; each
//   sample is one pass through the evaluation logic (one 24x17 multiply and compares).
// Reset: synchronous, active low; thresholds return to their defaults, alarm state clears.
`default_nettype none
module threshold_alarm_qualifier_top (
  input  wire        clk,
  input  wire        rst_n,
  taq_in_if.sink     in_bus,
  taq_out_if.source  out_bus,
  taq_cfg_if.sink    cfg_bus
);
  import taq_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  taq_cfg_t cfg;

  taq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input stage: holds one sample beat until the evaluation pass can retire it
  // ---------------------------------------------------------------------------
  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic signed [LEVEL_W-1:0] s1_sample_r;
  logic [TIME_W-1:0]         s1_now_r;

  // channel state: alarm flags, timer start and event count
  taq_state_t  st_r;
  taq_state_t  st_nxt;

  // result stage
  logic        out_valid_r;
  logic        out_valid_nxt;
  taq_result_t out_res_r;

  logic        res_valid;
  taq_result_t res;
  logic        in_fire;
  logic        s1_fire;

  // The sample in stage 1 retires when the result slot is free or being
  // drained this cycle; a sample that makes no event retires the same way,
  // so the state update stays in beat order.
  assign s1_fire        = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready   = !s1_valid_r || s1_fire;
  assign in_fire        = in_bus.valid && in_bus.ready;

  assign s1_valid_nxt   = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_bus.sample;
      s1_now_r    <= in_bus.now_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Evaluation pass
  // ---------------------------------------------------------------------------
  taq_eval u_eval (
    .cfg       (cfg),
    .st        (st_r),
    .sample    (s1_sample_r),
    .now_ms    (s1_now_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: an event waits here while stage 1 takes the next beat
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = res_valid;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.severity      = out_res_r.severity;
  assign out_bus.event_value   = out_res_r.event_value;
  assign out_bus.crossed_level = out_res_r.crossed_level;
  assign out_bus.held_ms       = out_res_r.held_ms;
  assign out_bus.event_time    = out_res_r.event_time;
  assign out_bus.event_count   = out_res_r.event_count;

`ifndef SYNTH
  // an event leaves the channel active
  a_event_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_valid) |=> st_r.active)
    else $error("channel not active after event");

  // a warning event only fires from an inactive channel
  a_warn_once: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_valid && !res.severity) |-> !st_r.active)
    else $error("repeated warning event while active");

  // without a pending excursion there is no alarm and no count
  a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.pending |-> (!st_r.active && (st_r.run_count == '0)))
    else $error("alarm state without pending excursion");

  // every delivered event carries a nonzero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.event_count != '0))
    else $error("event with zero count");
`endif

endmodule
`default_nettype wire

FILE: test/threshold_alarm_qualifier_top_tb.sv
// Self-checking testbench for the two-level threshold alarm qualifier.
`timescale 1ns / 1ps
module threshold_alarm_qualifier_top_tb;
  import taq_pkg::*;

  // One sensor reading waiting to be offered on the sample channel
  typedef struct {
    logic signed [LEVEL_W-1:0] sample;
    logic [TIME_W-1:0]         now_ms;
  } reading_t;

  // Handshake pacing of one phase: sender gaps and receiver stalls
  typedef enum int {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  // Cycles to let an item that raises no event clear the two register stages
  localparam int unsigned FLUSH_CYCLES = 4;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 98;
  localparam int unsigned CRIT_RUN_ITEMS = 40;

  logic clk;
  logic rst_n;

  taq_in_if  in_bus();
  taq_out_if out_bus();
  taq_cfg_if cfg_bus();

  threshold_alarm_qualifier_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Shadow of the alarm channel: thresholds as last written, plus alarm state
  logic signed [LEVEL_W-1:0] lvl_warn;
  logic signed [LEVEL_W-1:0] lvl_crit;
  logic [FRAC_W-1:0]         hyst_frac;
  logic [HOLD_W-1:0]         hold_ms;
  logic                      alarm_on;
  logic                      excursion_open;
  logic [TIME_W-1:0]         excursion_start;
  logic [COUNT_W-1:0]        event_run;

  reading_t    sample_backlog[$];   // readings not yet offered
  taq_result_t expected_events[$];  // events predicted but not yet seen
  reading_t    head_item;
  taq_result_t due;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned failures;
  logic [TIME_W-1:0] clock_ms;      // running timestamp of the random part

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: well beyond the slowest legal run (directed checks plus paced phases)
  initial begin
    #5_000_000;
    $display("FAIL threshold_alarm_qualifier_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Alarm prediction for one accepted sample beat. Below both levels the
  // channel may clear (exact hysteresis compare in 64 bits); otherwise the
  // excursion timer starts once, and an event follows when the hold time is met.
  // A warning repeats only after a clear; a critical fires on every sample once the hold is met.
  // ---------------------------------------------------------------------------
  task automatic qualify_sample(input logic signed [LEVEL_W-1:0] s,
                                input logic [TIME_W-1:0] now);
    logic              is_crit;
    logic              is_warn;
    logic              do_clear;
    logic [TIME_W-1:0] held;
    longint            lhs;
    longint            rhs;
    taq_result_t       ev;
    is_crit = (s >= lvl_crit);
    is_warn = !is_crit && (s >= lvl_warn);
    if (!is_crit && !is_warn) begin
      if (alarm_on) begin
        lhs = longint'(s) * 65536;
        rhs = longint'(lvl_warn) * (longint'(65536) - longint'(hyst_frac));
        do_clear = (lhs < rhs);
      end else begin
        do_clear = 1'b1;
      end
      if (do_clear) begin
        alarm_on       = 1'b0;
        excursion_open = 1'b0;
        event_run      = '0;
      end
      return;
    end
    if (!excursion_open) begin
      excursion_start = now;
      excursion_open  = 1'b1;
    end
    held = now - excursion_start;
    if (held < {16'd0, hold_ms}) return;
    if (is_warn && alarm_on) return;   // warning already reported this excursion
    alarm_on = 1'b1;
    if (event_run != COUNT_MAX) event_run = event_run + 1'b1;
    ev.severity      = is_crit;
    ev.event_value   = s;
    ev.crossed_level = is_crit ? lvl_crit : lvl_warn;
    ev.held_ms       = held;
    ev.event_time    = now;
    ev.event_count   = event_run;
    expected_events.push_back(ev);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endtask

  // Sample driver: a beat stays up until taken, then the next one (or a gap)
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) qualify_sample(in_bus.sample, in_bus.now_ms);
      if (!in_bus.valid || in_bus.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          head_item = sample_backlog.pop_front();
          in_bus.valid  <= 1'b1;
          in_bus.sample <= head_item.sample;
          in_bus.now_ms <= head_item.now_ms;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Event receiver backpressure
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Event monitor: every taken beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_events.size() == 0) begin
        $error("event beat with none predicted: value %h time %h",
               out_bus.event_value, out_bus.event_time);
        failures++;
      end else begin
        due = expected_events.pop_front();
        check_field("severity", 32'(due.severity), 32'(out_bus.severity));
        check_field("event_value", 32'(due.event_value), 32'(out_bus.event_value));
        check_field("crossed_level", 32'(due.crossed_level), 32'(out_bus.crossed_level));
        check_field("held_ms", due.held_ms, out_bus.held_ms);
        check_field("event_time", due.event_time, out_bus.event_time);
        check_field("event_count", 32'(due.event_count), 32'(out_bus.event_count));
      end
    end
  end

  // One register write; the shadow copy follows at the handshake
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_WARN_LEVEL:    lvl_warn  = data;
      CFG_CRIT_LEVEL:    lvl_crit  = data;
      CFG_HYST_FRACTION: hyst_frac = data[FRAC_W-1:0];
      CFG_MIN_HOLD_MS:   hold_ms   = data[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  // All four registers; upper data bits of the 16-bit ones carry junk
  task automatic load_thresholds(input logic signed [LEVEL_W-1:0] warn,
                                 input logic signed [LEVEL_W-1:0] crit,
                                 input logic [FRAC_W-1:0] hyst,
                                 input logic [HOLD_W-1:0] hold);
    write_reg(CFG_WARN_LEVEL, warn);
    write_reg(CFG_CRIT_LEVEL, crit);
    write_reg(CFG_HYST_FRACTION, {8'($urandom_range(255)), hyst});
    write_reg(CFG_MIN_HOLD_MS, {8'($urandom_range(255)), hold});
  endtask

  task automatic set_pace(input pace_t pace);
    send_gap_pct   = (pace == PACE_SEND_GAPS)   ? 65 : (pace == PACE_BOTH) ? 24 : 0;
    recv_stall_pct = (pace == PACE_RECV_STALLS) ? 65 : (pace == PACE_BOTH) ? 24 : 0;
  endtask

  task automatic push_item(input logic signed [LEVEL_W-1:0] s,
                           input logic [TIME_W-1:0] now);
    reading_t r;
    r.sample = s;
    r.now_ms = now;
    sample_backlog.push_back(r);
  endtask

  // Wait until the block is idle: all beats sent, all events seen, pipe flushed.
  // Checked mid-cycle so the driver's updates at the edge have settled.
  task automatic drain();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_bus.valid || expected_events.size() != 0);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [LEVEL_W-1:0] to_level(input longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[LEVEL_W-1:0];
  endfunction

  // Sample picked by band around the current levels, so excursions, holds,
  // the hysteresis band and clears all come up often
  function automatic logic signed [LEVEL_W-1:0] pick_sample();
    longint      w;
    longint      c;
    longint      thr;
    longint      lo;
    longint      hi;
    longint      v;
    int unsigned roll;
    w = lvl_warn;
    c = lvl_crit;
    thr = (w * (longint'(65536) - longint'(hyst_frac))) >>> 16;
    roll = $urandom_range(99);
    if (roll < 25) begin
      v = c + longint'($urandom_range(400));
    end else if (roll < 45) begin
      hi = c - w - 1;
      if (hi > 400) hi = 400;
      v = (hi >= 0) ? w + longint'($urandom_range(32'(hi))) : w;
    end else if (roll < 65) begin
      lo = ((thr < w) ? thr : w) - 3;
      hi = ((thr < w) ? w : thr) + 1;
      if (hi - lo > 2000) lo = hi - 2000;
      v = lo + longint'($urandom_range(32'(hi - lo)));
    end else if (roll < 80) begin
      v = w - 1 - longint'($urandom_range(20000));
    end else if (roll < 90) begin
      case ($urandom_range(3))
        0:       v = -64'sd8388608;
        1:       v = 64'sd8388607;
        2:       v = 0;
        default: v = -1;
      endcase
    end else begin
      v = longint'($signed(24'($urandom)));
    end
    return to_level(v);
  endfunction

  // Timestamps mostly move forward by up to about half the hold time;
  // some repeat, some step back, some jump anywhere
  function automatic logic [TIME_W-1:0] advance_time();
    int unsigned roll;
    int unsigned step;
    roll = $urandom_range(99);
    step = (hold_ms == 0) ? 20 : hold_ms / 2 + 1;
    if (roll < 80) clock_ms += $urandom_range(step);
    else if (roll >= 90 && roll < 95) clock_ms -= $urandom_range(1000, 1);
    else if (roll >= 95) clock_ms = $urandom;
    return clock_ms;
  endfunction

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    in_bus.now_ms  = '0;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_WARN_LEVEL;
    cfg_bus.data   = '0;
    failures       = 0;
    clock_ms       = '0;
    set_pace(PACE_FULL);
    lvl_warn        = WARN_LEVEL_RST;
    lvl_crit        = CRIT_LEVEL_RST;
    hyst_frac       = HYST_FRACTION_RST;
    hold_ms         = MIN_HOLD_MS_RST;
    alarm_on        = 1'b0;
    excursion_open  = 1'b0;
    excursion_start = '0;
    event_run       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset levels: warn 2.0, crit 4.0, 10% hysteresis, 100 ms hold
    push_item(0, 0);                  // idle, clears nothing
    push_item(600, 1000);             // warning excursion starts the timer
    push_item(600, 1050);             // held 50, too short
    push_item(600, 1100);             // hold met: warning event
    push_item(600, 1200);             // warning again while active: quiet
    push_item(1024, 1210);            // exactly critical: event
    push_item(24'sd8388607, 1220);    // largest sample
    push_item(500, 1230);             // inside hysteresis band: stays active
    push_item(460, 1240);             // below clearing level: clear
    push_item(-24'sd8388608, 1250);   // smallest sample
    push_item(600, 5000);             // new excursion
    push_item(600, 4000);             // time goes backwards: wrapped hold
    push_item(1100, 32'hFFFF_FFFF);   // latest timestamp
    push_item(-1, 0);                 // clear
    drain();

    // Half hysteresis makes the clearing level land exactly on 1.0
    load_thresholds(512, 1024, 16'd32768, 16'd0);
    push_item(600, 10);               // zero hold: event on first sample
    push_item(256, 20);               // exactly at clearing level: no clear
    push_item(600, 30);               // still active, no second warning
    push_item(255, 40);               // one below: clear
    push_item(600, 50);               // warning again after the clear
    drain();

    // Critical below warning: critical wins
    load_thresholds(1000, -100, 16'd0, 16'd0);
    push_item(0, 0);
    push_item(-101, 5);
    push_item(1500, 6);
    drain();

    // Unbroken critical run: the event count climbs on every sample
    load_thresholds(512, 1024, 16'd6554, 16'd0);
    for (int i = 0; i < CRIT_RUN_ITEMS; i++) push_item(2000, i);
    drain();

    // Random phases, each with its own thresholds and handshake pacing
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: load_thresholds(WARN_LEVEL_RST, CRIT_LEVEL_RST, HYST_FRACTION_RST,
                           MIN_HOLD_MS_RST);
        1: load_thresholds(-24'sd8388608, 24'sd8388607, 16'hFFFF, 16'd0);
        2: load_thresholds(24'sd8388607, -24'sd8388608, 16'd0, 16'hFFFF);
        default: begin
          longint w;
          w = longint'($urandom_range(4000)) - 2000;
          load_thresholds(24'(w), 24'(w + longint'($urandom_range(3000)) - 500),
                          16'($urandom_range(65535)), 16'($urandom_range(300)));
        end
      endcase
      set_pace(pace_t'(p % 4));
      clock_ms = (p == 3) ? 32'hFFFF_FF00 : $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) push_item(pick_sample(), advance_time());
      drain();
    end

    if (failures == 0) begin
      $display("PASS threshold_alarm_qualifier_top");
    end else begin
      $display("FAIL threshold_alarm_qualifier_top");
    end
    $finish;
  end

endmodule
